FILE: src/rto_est_pkg.sv
// Shared widths, constants, register indexes and types for the RTO estimator.
// Used by every module of the block; it depends on nothing else.
package rto_est_pkg;

  localparam int SAMPLE_W  = 40;
  localparam int US_W      = 30;
  localparam int GRAN_W    = 20;
  localparam int NS_W      = 40;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 40;

  // Sample in nanoseconds divided by 1000 as (sample >> 3) / 125, where the
  // division by 125 is a multiplication by a rounded-up reciprocal.
  localparam int DIV_PRE_SHIFT = 3;
  localparam int DIV_Y_W       = SAMPLE_W - DIV_PRE_SHIFT;
  localparam int DIV_SHIFT     = 44;
  localparam int DIV_M_W       = 38;
  localparam int DIV_HALF_W    = DIV_M_W / 2;
  localparam int DIV_PP_W      = DIV_Y_W + DIV_HALF_W;
  localparam int DIV_SUM_W     = DIV_Y_W + DIV_M_W;
  localparam int DIV_Q_W       = DIV_SUM_W - DIV_SHIFT;
  localparam longint unsigned RecipDiv = 125;
  localparam logic [DIV_M_W-1:0] DIV_M =
      DIV_M_W'(((64'd1 << DIV_SHIFT) + RecipDiv - 64'd1) / RecipDiv);
  localparam logic [DIV_HALF_W-1:0] DIV_M_LO = DIV_M[DIV_HALF_W-1:0];
  localparam logic [DIV_HALF_W-1:0] DIV_M_HI = DIV_M[DIV_M_W-1:DIV_HALF_W];

  localparam logic [US_W-1:0] US_MAX = {US_W{1'b1}};

  localparam int SPREAD_W = US_W + 2;
  localparam int SUM_W    = SPREAD_W + 1;
  localparam int SCALED_W = SUM_W + 10;
  localparam logic [SCALED_W-1:0] US_TO_NS = SCALED_W'(1000);

  localparam logic [CFG_IDX_W-1:0] CFG_GRANULARITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RTO_FLOOR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RTO_CEILING = 2'd2;

  localparam logic [GRAN_W-1:0] GRAN_RESET    = GRAN_W'(1000);
  localparam logic [NS_W-1:0]   FLOOR_RESET   = NS_W'(64'd200000000);
  localparam logic [NS_W-1:0]   CEILING_RESET = NS_W'(64'd120000000000);

  typedef struct packed {
    logic [GRAN_W-1:0] granularity_us;
    logic [NS_W-1:0]   rto_floor_ns;
    logic [NS_W-1:0]   rto_ceiling_ns;
  } rto_cfg_t;

endpackage

FILE: src/rto_est_div1000.sv
// Two-stage conversion of a nanosecond sample to microseconds, floored at one
// and saturated to 30 bits. Depends on rto_est_pkg.
module rto_est_div1000 (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [rto_est_pkg::SAMPLE_W-1:0]   in_sample_ns,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [rto_est_pkg::US_W-1:0]       out_us
);

  logic                                 pp_valid_r;
  logic [rto_est_pkg::DIV_PP_W-1:0]     pp_lo_r;
  logic [rto_est_pkg::DIV_PP_W-1:0]     pp_hi_r;
  logic [rto_est_pkg::DIV_PP_W-1:0]     pp_lo_nxt;
  logic [rto_est_pkg::DIV_PP_W-1:0]     pp_hi_nxt;
  logic [rto_est_pkg::DIV_Y_W-1:0]      y;
  logic                                 us_valid_r;
  logic [rto_est_pkg::US_W-1:0]         us_r;
  logic [rto_est_pkg::US_W-1:0]         us_nxt;
  logic [rto_est_pkg::DIV_SUM_W-1:0]    prod;
  logic [rto_est_pkg::DIV_Q_W-1:0]      quot;
  logic                                 pp_ready;

  assign pp_ready = !us_valid_r || out_ready;
  assign in_ready = !pp_valid_r || pp_ready;

  always_comb begin
    y = in_sample_ns[rto_est_pkg::SAMPLE_W-1:rto_est_pkg::DIV_PRE_SHIFT];
    pp_lo_nxt = {{rto_est_pkg::DIV_HALF_W{1'b0}}, y}
              * {{rto_est_pkg::DIV_Y_W{1'b0}}, rto_est_pkg::DIV_M_LO};
    pp_hi_nxt = {{rto_est_pkg::DIV_HALF_W{1'b0}}, y}
              * {{rto_est_pkg::DIV_Y_W{1'b0}}, rto_est_pkg::DIV_M_HI};
  end

  always_comb begin
    prod = {pp_hi_r, {rto_est_pkg::DIV_HALF_W{1'b0}}}
         + {{rto_est_pkg::DIV_HALF_W{1'b0}}, pp_lo_r};
    quot = prod[rto_est_pkg::DIV_SUM_W-1:rto_est_pkg::DIV_SHIFT];
    if (quot == '0) begin
      us_nxt = rto_est_pkg::US_W'(1);
    end else if (quot > {1'b0, rto_est_pkg::US_MAX}) begin
      us_nxt = rto_est_pkg::US_MAX;
    end else begin
      us_nxt = quot[rto_est_pkg::US_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_valid_r <= 1'b0;
      us_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        pp_valid_r <= in_valid;
        pp_lo_r    <= pp_lo_nxt;
        pp_hi_r    <= pp_hi_nxt;
      end
      if (pp_ready) begin
        us_valid_r <= pp_valid_r;
        us_r       <= us_nxt;
      end
    end
  end

  assign out_valid = us_valid_r;
  assign out_us    = us_r;

  // A converted sample is never zero, so it can never look like an unseeded state.
  a_us_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    us_valid_r |-> (us_r != '0))
    else $error("converted sample is zero");

endmodule

FILE: src/rto_est_update.sv
// Smoothed RTT and variation update; the state registers double as the stage
// output. Depends on rto_est_pkg.
module rto_est_update (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rto_est_pkg::US_W-1:0]  in_us,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rto_est_pkg::US_W-1:0]  out_smoothed_us,
  output logic [rto_est_pkg::US_W-1:0]  out_variance_us
);

  logic                          valid_r;
  logic [rto_est_pkg::US_W-1:0]  srtt_r;
  logic [rto_est_pkg::US_W-1:0]  var_r;
  logic [rto_est_pkg::US_W-1:0]  srtt_nxt;
  logic [rto_est_pkg::US_W-1:0]  var_nxt;
  logic [rto_est_pkg::US_W-1:0]  gap;
  logic                          load;

  assign in_ready = !valid_r || out_ready;
  assign load     = in_valid && in_ready;

  always_comb begin
    gap = (srtt_r > in_us) ? (srtt_r - in_us) : (in_us - srtt_r);
    if (srtt_r == '0) begin
      // First sample seeds the estimator.
      srtt_nxt = in_us;
      var_nxt  = in_us >> 1;
    end else begin
      var_nxt  = var_r - (var_r >> 2) + (gap >> 2);
      srtt_nxt = srtt_r - (srtt_r >> 3) + (in_us >> 3);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      srtt_r  <= '0;
      var_r   <= '0;
    end else begin
      if (in_ready) begin
        valid_r <= in_valid;
      end
      if (load) begin
        srtt_r <= srtt_nxt;
        var_r  <= var_nxt;
      end
    end
  end

  assign out_valid       = valid_r;
  assign out_smoothed_us = srtt_r;
  assign out_variance_us = var_r;

  a_seed_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (srtt_r != '0) |=> (srtt_r != '0))
    else $error("seeded smoothed RTT returned to zero");

  a_state_only_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    !load |=> ($stable(srtt_r) && $stable(var_r)))
    else $error("estimator state changed without a transaction");

endmodule

FILE: src/rto_est_timeout.sv
// Timeout computation: variation term, scaling to nanoseconds, then clamping
// into the result register. Depends on rto_est_pkg.
module rto_est_timeout (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rto_est_pkg::rto_cfg_t         cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rto_est_pkg::US_W-1:0]  in_smoothed_us,
  input  logic [rto_est_pkg::US_W-1:0]  in_variance_us,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rto_est_pkg::US_W-1:0]  out_smoothed_us,
  output logic [rto_est_pkg::US_W-1:0]  out_variance_us,
  output logic [rto_est_pkg::NS_W-1:0]  out_timeout_ns
);

  logic                              sc_valid_r;
  logic [rto_est_pkg::SCALED_W-1:0]  scaled_r;
  logic [rto_est_pkg::SCALED_W-1:0]  scaled_nxt;
  logic [rto_est_pkg::US_W-1:0]      sc_srtt_r;
  logic [rto_est_pkg::US_W-1:0]      sc_var_r;
  logic [rto_est_pkg::SPREAD_W-1:0]  spread4;
  logic [rto_est_pkg::SPREAD_W-1:0]  gran;
  logic [rto_est_pkg::SPREAD_W-1:0]  spread;
  logic [rto_est_pkg::SUM_W-1:0]     rto_us;
  logic [rto_est_pkg::SCALED_W-1:0]  floor_ext;
  logic [rto_est_pkg::SCALED_W-1:0]  ceil_ext;
  logic [rto_est_pkg::NS_W-1:0]      timeout_nxt;
  logic                              res_valid_r;
  logic [rto_est_pkg::US_W-1:0]      res_srtt_r;
  logic [rto_est_pkg::US_W-1:0]      res_var_r;
  logic [rto_est_pkg::NS_W-1:0]      res_timeout_r;
  logic                              sc_ready;

  assign sc_ready = !res_valid_r || out_ready;
  assign in_ready = !sc_valid_r || sc_ready;

  always_comb begin
    spread4 = {in_variance_us, 2'b00};
    gran    = {{(rto_est_pkg::SPREAD_W - rto_est_pkg::GRAN_W){1'b0}}, cfg.granularity_us};
    spread  = (spread4 < gran) ? gran : spread4;
    rto_us  = {3'b000, in_smoothed_us} + {1'b0, spread};
    scaled_nxt = {{(rto_est_pkg::SCALED_W - rto_est_pkg::SUM_W){1'b0}}, rto_us}
               * rto_est_pkg::US_TO_NS;
  end

  // The floor is tested first, so it wins even when it lies above the ceiling.
  always_comb begin
    floor_ext = {{(rto_est_pkg::SCALED_W - rto_est_pkg::NS_W){1'b0}}, cfg.rto_floor_ns};
    ceil_ext  = {{(rto_est_pkg::SCALED_W - rto_est_pkg::NS_W){1'b0}}, cfg.rto_ceiling_ns};
    if (scaled_r < floor_ext) begin
      timeout_nxt = cfg.rto_floor_ns;
    end else if (scaled_r > ceil_ext) begin
      timeout_nxt = cfg.rto_ceiling_ns;
    end else begin
      timeout_nxt = scaled_r[rto_est_pkg::NS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_valid_r  <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        sc_valid_r <= in_valid;
        scaled_r   <= scaled_nxt;
        sc_srtt_r  <= in_smoothed_us;
        sc_var_r   <= in_variance_us;
      end
      if (sc_ready) begin
        res_valid_r   <= sc_valid_r;
        res_srtt_r    <= sc_srtt_r;
        res_var_r     <= sc_var_r;
        res_timeout_r <= timeout_nxt;
      end
    end
  end

  assign out_valid       = res_valid_r;
  assign out_smoothed_us = res_srtt_r;
  assign out_variance_us = res_var_r;
  assign out_timeout_ns  = res_timeout_r;

endmodule

FILE: src/tcp_rto_estimator_top.sv
// Top level of the RTO estimator: configuration registers, input register and
// the conversion, update and timeout stages. Depends on rto_est_pkg and all submodules.
//
//   channel | handshake             | payload
//   --------+-----------------------+-----------------------------------------------
//   input   | in_valid / in_ready   | in_sample_ns
//   result  | out_valid / out_ready | out_smoothed_us, out_variance_us, out_timeout_ns
//   config  | cfg_wr_en             | cfg_index, cfg_data
//
// One transaction is accepted per cycle when the result side keeps up; each
// accepted input passes through the input register, two divider stages, the state
// update, scaling and the clamp register. The estimator state closes its loop in
// the single update stage. Reset restores the register defaults, clears the state
// and empties every stage. Each stage has its own valid bit, so a stall at the
// output fills bubbles before it reaches the input.
module tcp_rto_estimator_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [rto_est_pkg::SAMPLE_W-1:0]    in_sample_ns,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rto_est_pkg::US_W-1:0]        out_smoothed_us,
  output logic [rto_est_pkg::US_W-1:0]        out_variance_us,
  output logic [rto_est_pkg::NS_W-1:0]        out_timeout_ns,
  input  logic                                cfg_wr_en,
  input  logic [rto_est_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rto_est_pkg::CFG_DATA_W-1:0]  cfg_data
);

  rto_est_pkg::rto_cfg_t                 cfg_r;
  logic                                  in_valid_r;
  logic [rto_est_pkg::SAMPLE_W-1:0]      sample_r;
  logic                                  div_ready;
  logic                                  div_valid;
  logic [rto_est_pkg::US_W-1:0]          div_us;
  logic                                  upd_ready;
  logic                                  upd_valid;
  logic [rto_est_pkg::US_W-1:0]          upd_srtt;
  logic [rto_est_pkg::US_W-1:0]          upd_var;
  logic                                  tmo_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.granularity_us <= rto_est_pkg::GRAN_RESET;
      cfg_r.rto_floor_ns   <= rto_est_pkg::FLOOR_RESET;
      cfg_r.rto_ceiling_ns <= rto_est_pkg::CEILING_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        rto_est_pkg::CFG_GRANULARITY:
          cfg_r.granularity_us <= cfg_data[rto_est_pkg::GRAN_W-1:0];
        rto_est_pkg::CFG_RTO_FLOOR:   cfg_r.rto_floor_ns   <= cfg_data;
        rto_est_pkg::CFG_RTO_CEILING: cfg_r.rto_ceiling_ns <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = !in_valid_r || div_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
      sample_r   <= in_sample_ns;
    end
  end

  rto_est_div1000 u_div (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid_r),
    .in_ready     (div_ready),
    .in_sample_ns (sample_r),
    .out_valid    (div_valid),
    .out_ready    (upd_ready),
    .out_us       (div_us)
  );

  rto_est_update u_upd (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (div_valid),
    .in_ready        (upd_ready),
    .in_us           (div_us),
    .out_valid       (upd_valid),
    .out_ready       (tmo_ready),
    .out_smoothed_us (upd_srtt),
    .out_variance_us (upd_var)
  );

  rto_est_timeout u_tmo (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (upd_valid),
    .in_ready        (tmo_ready),
    .in_smoothed_us  (upd_srtt),
    .in_variance_us  (upd_var),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_smoothed_us (out_smoothed_us),
    .out_variance_us (out_variance_us),
    .out_timeout_ns  (out_timeout_ns)
  );

endmodule

FILE: bench/tcp_rto_estimator_top_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for tcp_rto_estimator_top: directed and random RTT samples
// are run through an in-bench estimator and every result transaction is compared.
// Depends on rto_est_pkg and the tcp_rto_estimator_top RTL.
module tcp_rto_estimator_top_tb;

  localparam int PIPE_LATENCY = 5;
  localparam int MAX_REPORTS = 10;
  localparam int RUN_LIMIT_NS = 20_000_000;
  localparam int STALL_CYCLES = 200;
  localparam logic [rto_est_pkg::CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;
  localparam logic [rto_est_pkg::NS_W-1:0] NS_ALL_ONES = {rto_est_pkg::NS_W{1'b1}};
  localparam logic [rto_est_pkg::GRAN_W-1:0] GRAN_ALL_ONES = {rto_est_pkg::GRAN_W{1'b1}};

  typedef struct packed {
    logic [rto_est_pkg::US_W-1:0] smoothed_us;
    logic [rto_est_pkg::US_W-1:0] variance_us;
    logic [rto_est_pkg::NS_W-1:0] timeout_ns;
  } rto_estimate_t;

  logic                               clk;
  logic                               rst_n;
  logic                               in_valid;
  logic                               in_ready;
  logic [rto_est_pkg::SAMPLE_W-1:0]   in_sample_ns;
  logic                               out_valid;
  logic                               out_ready;
  logic [rto_est_pkg::US_W-1:0]       out_smoothed_us;
  logic [rto_est_pkg::US_W-1:0]       out_variance_us;
  logic [rto_est_pkg::NS_W-1:0]       out_timeout_ns;
  logic                               cfg_wr_en;
  logic [rto_est_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rto_est_pkg::CFG_DATA_W-1:0] cfg_data;

  // Bench copy of the registers and of the estimator state.
  logic [rto_est_pkg::GRAN_W-1:0] gran_mirror;
  logic [rto_est_pkg::NS_W-1:0]   floor_mirror;
  logic [rto_est_pkg::NS_W-1:0]   ceiling_mirror;
  logic [63:0]                    srtt_mirror;
  logic [63:0]                    rttvar_mirror;

  rto_estimate_t expected_estimates[$];
  rto_estimate_t oldest_estimate;
  int            mismatch_count;
  int            samples_sent;
  int            settings_applied;
  bit            in_idle_on;
  bit            out_idle_on;
  int            out_hold_cycles;
  logic [63:0]   rtt_base_ns;

  tcp_rto_estimator_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample_ns    (in_sample_ns),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_smoothed_us (out_smoothed_us),
    .out_variance_us (out_variance_us),
    .out_timeout_ns  (out_timeout_ns),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Mismatches found");
    $finish;
  end

  // Applies one sample to the bench estimator and returns the expected result.
  function automatic rto_estimate_t advance_estimator(
      input logic [rto_est_pkg::SAMPLE_W-1:0] sample_ns);
    logic [63:0]   usec;
    logic [63:0]   gap;
    logic [63:0]   spread;
    logic [63:0]   tmo;
    rto_estimate_t est;
    usec = 64'(sample_ns) / 64'd1000;
    if (usec == 64'd0) usec = 64'd1;
    if (usec > 64'(rto_est_pkg::US_MAX)) usec = 64'(rto_est_pkg::US_MAX);
    if (srtt_mirror == 64'd0) begin
      srtt_mirror = usec;
      rttvar_mirror = usec >> 1;
    end else begin
      gap = (srtt_mirror > usec) ? srtt_mirror - usec : usec - srtt_mirror;
      rttvar_mirror = rttvar_mirror - (rttvar_mirror >> 2) + (gap >> 2);
      srtt_mirror = srtt_mirror - (srtt_mirror >> 3) + (usec >> 3);
    end
    srtt_mirror &= 64'(rto_est_pkg::US_MAX);
    rttvar_mirror &= 64'(rto_est_pkg::US_MAX);
    spread = rttvar_mirror << 2;
    if (spread < 64'(gran_mirror)) spread = 64'(gran_mirror);
    tmo = (srtt_mirror + spread) * 64'd1000;
    // The floor is tested first, so it wins even when it lies above the ceiling.
    if (tmo < 64'(floor_mirror)) tmo = 64'(floor_mirror);
    else if (tmo > 64'(ceiling_mirror)) tmo = 64'(ceiling_mirror);
    est.smoothed_us = srtt_mirror[rto_est_pkg::US_W-1:0];
    est.variance_us = rttvar_mirror[rto_est_pkg::US_W-1:0];
    est.timeout_ns = tmo[rto_est_pkg::NS_W-1:0];
    return est;
  endfunction

  // A 40-bit value of random magnitude, so that small and large values are both common.
  function automatic logic [rto_est_pkg::NS_W-1:0] rand_wide();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return rto_est_pkg::NS_W'(raw) >> $urandom_range(rto_est_pkg::NS_W - 1);
  endfunction

  // Mostly a jittered flow around a slowly changing base RTT, with some noise.
  function automatic logic [rto_est_pkg::SAMPLE_W-1:0] next_sample_ns();
    int          pick;
    logic [63:0] v;
    pick = $urandom_range(99);
    if (pick < 70) begin
      if ($urandom_range(99) < 5) rtt_base_ns = 64'(rand_wide());
      v = rtt_base_ns * 64'($urandom_range(150, 50)) / 64'd100;
      if (v > 64'(NS_ALL_ONES)) v = 64'(NS_ALL_ONES);
    end else if (pick < 80) begin
      v = 64'(rand_wide());
    end else if (pick < 90) begin
      v = 64'($urandom_range(2999));
    end else if (pick < 95) begin
      v = 64'(rto_est_pkg::SAMPLE_W'({$urandom, $urandom}));
    end else begin
      // Straddles the point where the microsecond value saturates.
      v = 64'(rto_est_pkg::US_MAX) * 64'd1000 - 64'd2000 + 64'($urandom_range(4000));
    end
    return v[rto_est_pkg::SAMPLE_W-1:0];
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] expected_val,
                               input logic [63:0] actual_val);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t: %s expected %0d, got %0d", $time, what, expected_val, actual_val);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_sample(input logic [rto_est_pkg::SAMPLE_W-1:0] sample_ns);
    while (in_idle_on && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample_ns <= sample_ns;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_estimates.push_back(advance_estimator(sample_ns));
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_estimates.size() != 0) @(negedge clk);
    repeat (PIPE_LATENCY) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [rto_est_pkg::CFG_IDX_W-1:0] index,
                           input logic [rto_est_pkg::CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    case (index)
      rto_est_pkg::CFG_GRANULARITY: gran_mirror = data[rto_est_pkg::GRAN_W-1:0];
      rto_est_pkg::CFG_RTO_FLOOR:   floor_mirror = data[rto_est_pkg::NS_W-1:0];
      rto_est_pkg::CFG_RTO_CEILING: ceiling_mirror = data[rto_est_pkg::NS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [rto_est_pkg::CFG_DATA_W-1:0] gran_data,
                                input logic [rto_est_pkg::NS_W-1:0] floor_ns,
                                input logic [rto_est_pkg::NS_W-1:0] ceiling_ns);
    wait_drain();
    cfg_write(rto_est_pkg::CFG_GRANULARITY, gran_data);
    cfg_write(rto_est_pkg::CFG_RTO_FLOOR, floor_ns);
    cfg_write(rto_est_pkg::CFG_RTO_CEILING, ceiling_ns);
    settings_applied++;
  endtask

  task automatic test_seed_and_truncation();
    // A zero sample seeds the state with one microsecond and no variation.
    send_sample(40'd0);
    send_sample(40'd999);
    send_sample(40'd1000);
    send_sample(40'd1999);
    send_sample(40'd123_456_789);
  endtask

  task automatic test_sample_saturation();
    send_sample(NS_ALL_ONES);
    send_sample(40'd1_000_000_000_000);
    send_sample(40'd1_073_741_823_999);
    send_sample(40'd1_073_741_824_000);
    send_sample(40'd0);
  endtask

  task automatic test_register_extremes();
    apply_settings(rto_est_pkg::CFG_DATA_W'(GRAN_ALL_ONES), '0, NS_ALL_ONES);
    send_sample(40'd50_000);
    send_sample(40'd900_000_000_000);
    apply_settings('0, '0, '0);
    send_sample(40'd1);
    send_sample(40'd5_000_000);
    // Floor above the ceiling, first with the timeout under the floor and over the ceiling, then above both.
    apply_settings('0, NS_ALL_ONES, '0);
    send_sample(40'd3_000);
    send_sample(40'd700_000_000_000);
    apply_settings(rto_est_pkg::CFG_DATA_W'(1000), rto_est_pkg::NS_W'(500_000_000),
                   rto_est_pkg::NS_W'(100_000_000));
    send_sample(40'd1_000);
    send_sample(40'd900_000_000_000);
    // A write to the unmapped index must leave every register as it was.
    apply_settings(rto_est_pkg::CFG_DATA_W'(rto_est_pkg::GRAN_RESET),
                   rto_est_pkg::FLOOR_RESET, rto_est_pkg::CEILING_RESET);
    cfg_write(CFG_UNMAPPED, NS_ALL_ONES);
    send_sample(40'd40_000_000);
    send_sample(40'd60_000_000);
  endtask

  task automatic test_random_settings(input int phases, input int per_phase);
    logic [rto_est_pkg::GRAN_W-1:0] gran;
    logic [rto_est_pkg::NS_W-1:0]   lo;
    logic [rto_est_pkg::NS_W-1:0]   hi;
    logic [rto_est_pkg::NS_W-1:0]   swap;
    for (int p = 0; p < phases; p++) begin
      case ($urandom_range(9))
        0:       gran = '0;
        1:       gran = GRAN_ALL_ONES;
        default: gran = rto_est_pkg::GRAN_W'(rand_wide());
      endcase
      lo = ($urandom_range(9) == 0) ? '0 : rand_wide();
      hi = ($urandom_range(9) == 0) ? NS_ALL_ONES : rand_wide();
      if ($urandom_range(3) != 0 && lo > hi) begin
        swap = lo;
        lo = hi;
        hi = swap;
      end
      // Bits above the granularity field are sometimes set; they must be dropped.
      apply_settings({$urandom_range(1) ? rto_est_pkg::GRAN_W'($urandom)
                                        : rto_est_pkg::GRAN_W'(0), gran}, lo, hi);
      for (int i = 0; i < per_phase; i++) send_sample(next_sample_ns());
    end
  endtask

  task automatic test_back_to_back(input int count);
    apply_settings(rto_est_pkg::CFG_DATA_W'(rto_est_pkg::GRAN_RESET),
                   rto_est_pkg::FLOOR_RESET, rto_est_pkg::CEILING_RESET);
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    for (int i = 0; i < count; i++) send_sample(next_sample_ns());
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
  endtask

  task automatic test_output_stall(input int count);
    // The result side holds off while samples keep coming, so the pipe fills.
    out_hold_cycles = STALL_CYCLES;
    for (int i = 0; i < count; i++) send_sample(next_sample_ns());
  endtask

  // Result-side ready, with random idling and an occasional long hold-off.
  initial begin
    forever begin
      @(negedge clk);
      if (out_hold_cycles > 0) begin
        out_ready <= 1'b0;
        out_hold_cycles--;
      end else if (out_idle_on) begin
        out_ready <= ($urandom_range(99) >= 15);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_estimates.size() == 0) begin
        note_mismatch("result transaction with nothing pending, timeout_ns", 64'd0,
                      64'(out_timeout_ns));
      end else begin
        oldest_estimate = expected_estimates.pop_front();
        if (out_smoothed_us !== oldest_estimate.smoothed_us)
          note_mismatch("smoothed_us", 64'(oldest_estimate.smoothed_us), 64'(out_smoothed_us));
        if (out_variance_us !== oldest_estimate.variance_us)
          note_mismatch("variance_us", 64'(oldest_estimate.variance_us), 64'(out_variance_us));
        if (out_timeout_ns !== oldest_estimate.timeout_ns)
          note_mismatch("timeout_ns", 64'(oldest_estimate.timeout_ns), 64'(out_timeout_ns));
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample_ns = '0;
    out_ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
    out_hold_cycles = 0;
    mismatch_count = 0;
    samples_sent = 0;
    settings_applied = 0;
    rtt_base_ns = 64'd200_000_000;
    gran_mirror = rto_est_pkg::GRAN_RESET;
    floor_mirror = rto_est_pkg::FLOOR_RESET;
    ceiling_mirror = rto_est_pkg::CEILING_RESET;
    srtt_mirror = 64'd0;
    rttvar_mirror = 64'd0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_seed_and_truncation();
    test_sample_saturation();
    test_register_extremes();
    test_random_settings(5, 300);
    test_back_to_back(300);
    test_output_stall(150);
    wait_drain();

    if (expected_estimates.size() != 0)
      note_mismatch("pending estimates left at the end", 64'd0,
                    64'(expected_estimates.size()));
    $display("Checked %0d RTT samples over %0d register settings, covering seeding,",
             samples_sent, settings_applied);
    $display("saturation, clamping with the floor above the ceiling and a long output stall.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/rto_est_pkg.sv
src/rto_est_div1000.sv
src/rto_est_update.sv
src/rto_est_timeout.sv
src/tcp_rto_estimator_top.sv
bench/tcp_rto_estimator_top_tb.sv
